// ===== rtl/sqat_pkg.sv =====
`default_nettype none

package sqat_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Request kinds
   localparam logic KIND_CODE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Scan-code set 1 codes with special handling
   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
   localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
   localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
   localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
   localparam logic [7:0] SC_BREAK_BIT    = 8'h80;
   localparam logic [7:0] SC_OUT_OF_RANGE = 8'h7F;

   localparam logic [7:0] ASCII_LOWER_A   = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z   = 8'h7A;
   localparam logic [7:0] ASCII_CASE_BIT  = 8'h20;

   typedef struct packed {
      logic       kind;
      logic [7:0] scancode;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] ascii;
      logic       valid_res;
   } rsp_payload_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_FETCH
   } state_type;

   // Unshifted characters for make codes 0x00 to 0x7F.
   localparam logic [7:0] PLAIN_MAP [128] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Shifted characters for make codes 0x00 to 0x3F; higher codes are unshifted.
   localparam logic [7:0] SHIFT_MAP [64] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Translates one queued byte to ASCII. Zero, break codes and 0x7F give zero.
   function automatic logic [7:0] translate(input logic [7:0] code,
                                             input logic       shift,
                                             input logic       caps);
      logic [7:0] ch;
      ch = PLAIN_MAP[code[6:0]];
      if ((code == 8'h00) || ((code & SC_BREAK_BIT) != 8'h00) || (code == SC_OUT_OF_RANGE)) begin
         ch = 8'h00;
      end else if (shift) begin
         if (code[6] == 1'b0) begin
            ch = SHIFT_MAP[code[5:0]];
         end
      end else if (caps && (ch >= ASCII_LOWER_A) && (ch <= ASCII_LOWER_Z)) begin
         ch = ch - ASCII_CASE_BIT;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/scancode_queue_ascii_translator_core.sv =====
`default_nettype none

// Scan-code set 1 keyboard queue with ASCII translation. A request of kind 0
// delivers one raw keyboard byte: shift make and break codes update the shift
// flags, ctrl and alt codes are discarded, and any other byte is written to a
// 128-entry FIFO held in a synchronous RAM (dropped when the FIFO is full).
// Such a request produces no response. A request of kind 1
// pops the oldest byte and returns its ASCII value through the shift, caps lock
// or plain table; an empty FIFO gives valid_res = 0 and ascii = 0. A read
// request holds off the next request until the registered RAM read is done
// and the fetch state has translated the byte and loaded the response register.
// The fetch state is held for as long as an earlier response is still
// waiting in the response register and is not taken.
// The response register lets a new request be taken while a response waits.
module scancode_queue_ascii_translator_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  sqat_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output sqat_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_we,
   input  wire                        csr_wdata
);

   import sqat_pkg::*;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             lshift_ff, lshift_in;
   logic             rshift_ff, rshift_in;
   logic             caps_ff, caps_in;
   logic             empty_ff, empty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic [7:0]       code_mem_ff [QUEUE_DEPTH];
   logic [7:0]       mem_rdata_ff;

   logic             req_fire;
   logic             code_fire;
   logic             read_fire;
   logic             push_en;
   logic             rsp_load;
   logic             slot_free;
   logic             is_special;

   // Handshake decode
   assign req_fire  = req_valid && req_ready;
   assign code_fire = req_fire && (req_payload.kind == KIND_CODE);
   assign read_fire = req_fire && (req_payload.kind == KIND_READ);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Codes that never enter the queue.
   always_comb begin
      unique case (req_payload.scancode)
         SC_LSHIFT_MAKE, SC_LSHIFT_BREAK, SC_RSHIFT_MAKE, SC_RSHIFT_BREAK,
         SC_CTRL_MAKE, SC_CTRL_BREAK, SC_ALT_MAKE, SC_ALT_BREAK: is_special = 1'b1;
         default:                                                is_special = 1'b0;
      endcase
   end

   assign push_en = code_fire && !is_special && (count_ff != CNT_W'(QUEUE_DEPTH));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (read_fire) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State machine outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_FETCH: rsp_load  = slot_free;
         default: begin
            req_ready = 1'b0;
            rsp_load  = 1'b0;
         end
      endcase
   end

   // Pointers, fill count, shift flags and caps lock.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      lshift_in = lshift_ff;
      rshift_in = rshift_ff;
      caps_in   = csr_we ? csr_wdata : caps_ff;
      empty_in  = empty_ff;

      if (code_fire) begin
         case (req_payload.scancode)
            SC_LSHIFT_MAKE:  lshift_in = 1'b1;
            SC_LSHIFT_BREAK: lshift_in = 1'b0;
            SC_RSHIFT_MAKE:  rshift_in = 1'b1;
            SC_RSHIFT_BREAK: rshift_in = 1'b0;
            default:         lshift_in = lshift_ff;
         endcase
      end

      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end

      if (read_fire) begin
         empty_in = (count_ff == '0);
      end

      if (rsp_load && !empty_ff) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.valid_res = !empty_ff;
         rsp_payload_in.ascii     = empty_ff ? 8'h00
                                             : translate(mem_rdata_ff, lshift_ff || rshift_ff,
                                                         caps_ff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         lshift_ff    <= 1'b0;
         rshift_ff    <= 1'b0;
         caps_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         lshift_ff    <= lshift_in;
         rshift_ff    <= rshift_in;
         caps_ff      <= caps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      empty_ff       <= empty_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Queue memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (push_en) begin
         code_mem_ff[wr_ptr_ff] <= req_payload.scancode;
      end
   end

   always_ff @(posedge clock) begin
      if (read_fire) begin
         mem_rdata_ff <= code_mem_ff[rd_ptr_ff];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== rtl/sqat_checker.sv =====
`default_nettype none

module sqat_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input sqat_pkg::req_payload_type  req_payload,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input sqat_pkg::rsp_payload_type  rsp_payload
);

   import sqat_pkg::*;

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // An empty-queue response carries no character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.valid_res |-> rsp_payload.ascii == 8'h00)
      else $error("empty response with non-zero character");

   // Every accepted read request has a response pending once the fetch state has passed.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_payload.kind == KIND_READ) |=> ##1 rsp_valid)
      else $error("read request without response");

   // A new response only follows a read being serviced, when requests are held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a read in progress");

endmodule

bind scancode_queue_ascii_translator_core sqat_checker u_sqat_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== verif/sqat_key_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the scan-code queue. It keeps its own copy of the
// queue, the shift flags and caps lock, works out the expected key for every read
// request, and compares each response with the oldest key still expected.
module sqat_key_checker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire                       req_ready,
   input  sqat_pkg::req_payload_type req_payload,
   input  wire                       rsp_valid,
   input  wire                       rsp_ready,
   input  sqat_pkg::rsp_payload_type rsp_payload,
   input  wire                       csr_we,
   input  wire                       csr_wdata,
   output int                        mismatch_count,
   output int                        keys_pending
);

   import sqat_pkg::*;

   // Unshifted characters for make codes 0x00 to 0x7F.
   localparam logic [7:0] KEY_PLAIN [128] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Shifted characters for make codes 0x00 to 0x3F.
   localparam logic [7:0] KEY_SHIFTED [64] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   logic [7:0]      code_copy [QUEUE_DEPTH];
   int              slot_wr;
   int              slot_rd;
   int              queued;
   logic            shift_left;
   logic            shift_right;
   logic            caps_on;
   rsp_payload_type expected_keys [$];

   initial begin
      mismatch_count = 0;
      keys_pending   = 0;
   end

   // Maps one queued byte to its character under the current modifiers.
   function automatic logic [7:0] key_to_ascii(input logic [7:0] code);
      logic [7:0] ch;
      if ((code == 8'h00) || (code >= SC_OUT_OF_RANGE)) begin
         return 8'h00;
      end
      if (shift_left || shift_right) begin
         return (code < 8'h40) ? KEY_SHIFTED[code[5:0]] : KEY_PLAIN[code[6:0]];
      end
      ch = KEY_PLAIN[code[6:0]];
      if (caps_on && (ch >= ASCII_LOWER_A) && (ch <= ASCII_LOWER_Z)) begin
         ch = ch - ASCII_CASE_BIT;
      end
      return ch;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Applies one accepted request to the local copy of the queue.
   task automatic apply_request(input req_payload_type item);
      logic [7:0] popped;
      if (item.kind == KIND_CODE) begin
         case (item.scancode)
            SC_LSHIFT_MAKE: shift_left = 1'b1;
            SC_LSHIFT_BREAK: shift_left = 1'b0;
            SC_RSHIFT_MAKE: shift_right = 1'b1;
            SC_RSHIFT_BREAK: shift_right = 1'b0;
            SC_CTRL_MAKE, SC_CTRL_BREAK, SC_ALT_MAKE, SC_ALT_BREAK: ;
            default: begin
               // A full queue drops the byte.
               if (queued < QUEUE_DEPTH) begin
                  code_copy[slot_wr] = item.scancode;
                  slot_wr = (slot_wr + 1) % QUEUE_DEPTH;
                  queued++;
               end
            end
         endcase
      end else if (queued == 0) begin
         expected_keys.push_back(rsp_payload_type'{ascii: 8'h00, valid_res: 1'b0});
      end else begin
         popped = code_copy[slot_rd];
         slot_rd = (slot_rd + 1) % QUEUE_DEPTH;
         queued--;
         expected_keys.push_back(rsp_payload_type'{ascii: key_to_ascii(popped),
                                                   valid_res: 1'b1});
      end
   endtask

   // Everything is sampled at the clock edge; responses are checked before the
   // request of the same edge is applied, since they belong to earlier requests.
   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         slot_wr     = 0;
         slot_rd     = 0;
         queued      = 0;
         shift_left  = 1'b0;
         shift_right = 1'b0;
         caps_on     = 1'b0;
         expected_keys.delete();
      end else begin
         if (csr_we) begin
            caps_on = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_keys.size() == 0) begin
               report_mismatch("response with no read pending", rsp_payload.ascii, 8'h00);
            end else begin
               want = expected_keys.pop_front();
               if (rsp_payload.ascii !== want.ascii) begin
                  report_mismatch("ascii", rsp_payload.ascii, want.ascii);
               end
               if (rsp_payload.valid_res !== want.valid_res) begin
                  report_mismatch("valid_res", {7'd0, rsp_payload.valid_res},
                                  {7'd0, want.valid_res});
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_payload);
         end
      end
      keys_pending = expected_keys.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sqat_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   // Directed requests: extremes, every special code, and shifted reads.
   localparam logic [8:0] DIRECTED [25] = '{
      {KIND_READ, 8'h00},                                      // read while empty
      {KIND_CODE, 8'h1E}, {KIND_CODE, 8'h02}, {KIND_CODE, 8'h47},
      {KIND_CODE, 8'h00}, {KIND_CODE, 8'h7F}, {KIND_CODE, 8'hFF},
      {KIND_CODE, 8'h72}, {KIND_CODE, 8'h10},
      {KIND_CODE, SC_CTRL_MAKE}, {KIND_CODE, SC_CTRL_BREAK},
      {KIND_CODE, SC_ALT_MAKE}, {KIND_CODE, SC_ALT_BREAK},
      {KIND_CODE, SC_LSHIFT_MAKE},
      {KIND_READ, 8'hFF}, {KIND_READ, 8'h55},
      {KIND_CODE, SC_LSHIFT_BREAK}, {KIND_CODE, SC_RSHIFT_MAKE},
      {KIND_READ, 8'hAA},
      {KIND_CODE, SC_RSHIFT_BREAK},
      {KIND_READ, 8'h00}, {KIND_READ, 8'h01}, {KIND_READ, 8'h80},
      {KIND_READ, 8'h7F}, {KIND_READ, 8'hFE}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_we = 1'b0;
   logic            csr_wdata = 1'b0;

   int mismatch_count;
   int keys_pending;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit long_hold = 1'b0;

   scancode_queue_ascii_translator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   sqat_key_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .keys_pending   (keys_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("scancode_queue_ascii_translator_core verification failed");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold-off when one is asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offers one request and returns at the edge where it is taken, after any
   // idle cycles that follow it.
   task automatic offer_request(input req_payload_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stops offering until every expected key has come back and the block has
   // had time to finish any byte still being queued. A clock edge passes first so
   // that a read taken at the current edge is already counted as pending.
   task automatic wait_for_keys();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (keys_pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_caps_lock(input logic on);
      wait_for_keys();
      csr_we    <= 1'b1;
      csr_wdata <= on;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random request mix: plenty of reads, shift presses around key bytes,
   // some ctrl and alt noise, and raw bytes of any value.
   function automatic req_payload_type random_request();
      req_payload_type item;
      int              pick;
      pick          = $urandom_range(99);
      item.kind     = KIND_CODE;
      item.scancode = 8'($urandom_range(255));
      if (pick < 40) begin
         item.kind = KIND_READ;
      end else if (pick < 52) begin
         case ($urandom_range(3))
            0: item.scancode = SC_LSHIFT_MAKE;
            1: item.scancode = SC_LSHIFT_BREAK;
            2: item.scancode = SC_RSHIFT_MAKE;
            default: item.scancode = SC_RSHIFT_BREAK;
         endcase
      end else if (pick < 56) begin
         case ($urandom_range(3))
            0: item.scancode = SC_CTRL_MAKE;
            1: item.scancode = SC_CTRL_BREAK;
            2: item.scancode = SC_ALT_MAKE;
            default: item.scancode = SC_ALT_BREAK;
         endcase
      end else if (pick < 76) begin
         item.scancode = 8'($urandom_range(8'h32, 8'h02));
      end
      return item;
   endfunction

   task automatic random_requests(input int count);
      repeat (count) offer_request(random_request());
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests with caps lock off.
      set_caps_lock(1'b0);
      foreach (DIRECTED[i]) offer_request(req_payload_type'(DIRECTED[i]));

      // No idling on either side.
      set_caps_lock(1'b1);
      random_requests(200);

      // Sender idle most of the time.
      set_caps_lock(1'b0);
      idle_pct = 63;
      random_requests(200);

      // Receiver stalling; the queue is filled past full first.
      set_caps_lock(1'b1);
      idle_pct  = 0;
      stall_pct = 63;
      repeat (150) begin
         offer_request(req_payload_type'{kind: KIND_CODE,
                                         scancode: 8'($urandom_range(8'h19, 8'h10))});
      end
      random_requests(150);

      // Long receiver hold-off while requests keep coming, then a full drain.
      set_caps_lock(1'b0);
      long_hold = 1'b1;
      random_requests(30);
      wait_for_keys();

      // Both sides idling now and then.
      idle_pct  = 17;
      stall_pct = 17;
      random_requests(200);

      wait_for_keys();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("scancode_queue_ascii_translator_core verification clean");
      end else begin
         $display("scancode_queue_ascii_translator_core verification failed");
      end
      $finish;
   end

endmodule
